[rtl/dual_terminator_command_deframer_macros.svh]
// Assertion macros shared by the deframer checker.
`ifndef DUAL_TERMINATOR_COMMAND_DEFRAMER_MACROS_SVH
`define DUAL_TERMINATOR_COMMAND_DEFRAMER_MACROS_SVH

// Checked only while the block is out of reset.
`define DTCD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deframer assertion failed");

// Checked on every clock edge, reset included.
`define DTCD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("deframer reset assertion failed");

`endif

[rtl/dtcd_pkg.sv]
// Shared constants and types of the command deframer.
package dtcd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int USED_W       = PTR_W + 1;

    localparam logic [PTR_W-1:0] MAX_LEN = PTR_W'(BUFFER_DEPTH - 1);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_FF = 8'hFF;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int OB_CNT_W = OB_PTR_W + 1;

    typedef struct packed {
        logic [PTR_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmdq_in;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmdq_out;

endpackage

[rtl/dtcd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module dtcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dtcd_front.sv]
// Front end: classifies received bytes, writes them into the ring and posts frame ends.
module dtcd_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_rx_byte,
    input  logic                     i_slot_free,
    input  logic                     i_cmdq_full,
    output dtcd_pkg::t_cmdq_in       o_cmdq,
    output logic                     o_we,
    output logic [dtcd_pkg::PTR_W-1:0] o_waddr,
    output logic [7:0]               o_wdata
);

    logic [1:0]                      r_ff_run, n_ff_run;
    logic [dtcd_pkg::PTR_W-1:0]      r_len, n_len;
    logic [dtcd_pkg::PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [dtcd_pkg::USED_W-1:0]     r_used, n_used;

    logic accept;
    logic frame_end;
    logic keep;
    logic write;

    // The ring may also hold bytes of frames still being drained, so a full
    // ring or a full command queue holds the sender off.
    assign o_stall = (r_used == dtcd_pkg::USED_W'(dtcd_pkg::BUFFER_DEPTH)) || i_cmdq_full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_ff_run  = r_ff_run;
        frame_end = 1'b0;
        keep      = 1'b0;
        if (accept) begin
            priority if (i_rx_byte == dtcd_pkg::CHAR_CR) begin
                n_ff_run = r_ff_run;
            end else if (i_rx_byte == dtcd_pkg::CHAR_LF) begin
                frame_end = 1'b1;
            end else if (i_rx_byte == dtcd_pkg::CHAR_FF) begin
                if (r_ff_run == 2'd2) begin
                    n_ff_run  = 2'd0;
                    frame_end = 1'b1;
                end else begin
                    n_ff_run = r_ff_run + 2'd1;
                    keep     = 1'b1;
                end
            end else begin
                n_ff_run = 2'd0;
                keep     = 1'b1;
            end
        end
    end

    // Bytes beyond the frame limit are dropped but still counted in the 0xFF run.
    assign write = keep && (r_len != dtcd_pkg::MAX_LEN);

    always_comb begin
        n_len    = r_len;
        n_wr_ptr = r_wr_ptr;
        if (frame_end) begin
            n_len = '0;
        end else if (write) begin
            n_len    = r_len + dtcd_pkg::PTR_W'(1);
            n_wr_ptr = r_wr_ptr + dtcd_pkg::PTR_W'(1);
        end
        n_used = r_used + dtcd_pkg::USED_W'(write) - dtcd_pkg::USED_W'(i_slot_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_run <= 2'd0;
            r_len    <= '0;
            r_wr_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_ff_run <= n_ff_run;
            r_len    <= n_len;
            r_wr_ptr <= n_wr_ptr;
            r_used   <= n_used;
        end
    end

    assign o_cmdq.push    = frame_end && (r_len != '0);
    assign o_cmdq.cmd.len = r_len;
    assign o_we           = write;
    assign o_waddr        = r_wr_ptr;
    assign o_wdata        = i_rx_byte;

endmodule

[rtl/dtcd_cmdq.sv]
// Short queue of completed frame lengths between the front and back ends.
module dtcd_cmdq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtcd_pkg::t_cmdq_in   i_cmdq,
    output logic                 o_full,
    output dtcd_pkg::t_cmdq_out  o_cmdq,
    input  logic                 i_pop
);

    dtcd_pkg::t_cmd                  r_entry [dtcd_pkg::CMDQ_DEPTH];
    logic [dtcd_pkg::CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [dtcd_pkg::CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [dtcd_pkg::CMDQ_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full       = (r_cnt == dtcd_pkg::CMDQ_CNT_W'(dtcd_pkg::CMDQ_DEPTH));
    assign o_cmdq.valid = (r_cnt != '0);
    assign o_cmdq.cmd   = r_entry[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt + dtcd_pkg::CMDQ_CNT_W'(i_cmdq.push)
                      - dtcd_pkg::CMDQ_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmdq.push) begin
                r_wr_ptr <= r_wr_ptr + dtcd_pkg::CMDQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + dtcd_pkg::CMDQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmdq.push) begin
            r_entry[r_wr_ptr] <= i_cmdq.cmd;
        end
    end

endmodule

[rtl/dtcd_back.sv]
// Back end: reads completed frames out of the ring and presents them byte by byte.
module dtcd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtcd_pkg::t_cmdq_out        i_cmdq,
    output logic                       o_pop,
    output logic                       o_re,
    output logic [dtcd_pkg::PTR_W-1:0] o_raddr,
    input  logic [7:0]                 i_rdata,
    output logic                       o_slot_free,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_frame_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

    t_back_state                     r_state, n_state;
    logic [dtcd_pkg::PTR_W-1:0]      r_remain, n_remain;
    logic [dtcd_pkg::PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic                            r_inflight;
    logic                            r_inflight_last;

    logic [7:0]                      r_ob_byte [dtcd_pkg::OB_DEPTH];
    logic                            r_ob_last [dtcd_pkg::OB_DEPTH];
    logic [dtcd_pkg::OB_PTR_W-1:0]   r_ob_wr;
    logic [dtcd_pkg::OB_PTR_W-1:0]   r_ob_rd;
    logic [dtcd_pkg::OB_CNT_W-1:0]   r_ob_cnt;

    logic [dtcd_pkg::OB_CNT_W-1:0]   occ;
    logic                            out_pop;
    logic                            credit;
    logic                            issue;

    assign o_valid      = (r_ob_cnt != '0);
    assign o_frame_byte = r_ob_byte[r_ob_rd];
    assign o_frame_last = r_ob_last[r_ob_rd];
    assign out_pop      = o_valid && !i_stall;

    // A read is issued only if its data will find a free slot in the output buffer.
    assign occ    = r_ob_cnt + dtcd_pkg::OB_CNT_W'(r_inflight);
    assign credit = (occ < dtcd_pkg::OB_CNT_W'(dtcd_pkg::OB_DEPTH)) || out_pop;
    assign issue  = (r_state == ST_RUN) && credit;
    assign o_pop  = (r_state == ST_IDLE) && i_cmdq.valid;

    assign o_re        = issue;
    assign o_raddr     = r_rd_ptr;
    assign o_slot_free = issue;

    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        n_rd_ptr = r_rd_ptr;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_remain = i_cmdq.cmd.len;
                    n_state  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    n_rd_ptr = r_rd_ptr + dtcd_pkg::PTR_W'(1);
                    n_remain = r_remain - dtcd_pkg::PTR_W'(1);
                    if (r_remain == dtcd_pkg::PTR_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_remain   <= '0;
            r_rd_ptr   <= '0;
            r_inflight <= 1'b0;
            r_ob_wr    <= '0;
            r_ob_rd    <= '0;
            r_ob_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_remain   <= n_remain;
            r_rd_ptr   <= n_rd_ptr;
            r_inflight <= issue;
            r_ob_cnt   <= r_ob_cnt + dtcd_pkg::OB_CNT_W'(r_inflight)
                                   - dtcd_pkg::OB_CNT_W'(out_pop);
            if (r_inflight) begin
                r_ob_wr <= r_ob_wr + dtcd_pkg::OB_PTR_W'(1);
            end
            if (out_pop) begin
                r_ob_rd <= r_ob_rd + dtcd_pkg::OB_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inflight_last <= issue && (r_remain == dtcd_pkg::PTR_W'(1));
        if (r_inflight) begin
            r_ob_byte[r_ob_wr] <= i_rdata;
            r_ob_last[r_ob_wr] <= r_inflight_last;
        end
    end

endmodule

[rtl/dual_terminator_command_deframer.sv]
// Top level of the dual-terminator command deframer.
//
// Input channel: one received serial byte per transaction on i_rx_byte, taken
// when i_valid is high and o_stall is low. A frame ends at a line feed or at
// the third 0xFF in a row, counted across CR and LF; neither is ever stored.
// Output channel: the stored bytes of each completed non-empty frame, in order,
// on o_frame_byte with o_frame_last marking the final one, taken when o_valid
// is high and i_stall is low.
// Throughput: an input byte is normally taken every cycle. Bytes go into a
// 64-entry ring; a command queue of two frame lengths sits between the front
// end and the drain engine. o_stall rises while the ring or that queue is full.
// Output path: a completed frame's length passes through the command queue to
// the drain engine, which reads its bytes from the ring through its registered
// read port into the two-entry output buffer; within a frame the bytes follow
// one per cycle while i_stall is low.
// Reset (synchronous, active low) empties the ring, the queue and the output
// buffer; o_stall is low the cycle after. A stalled receiver holds the current
// byte steady; the front end takes input until the ring or the queue fills.
module dual_terminator_command_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_frame_last
);

    dtcd_pkg::t_cmdq_in          cmdq_in;
    dtcd_pkg::t_cmdq_out         cmdq_out;
    logic                        cmdq_full;
    logic                        cmdq_pop;
    logic                        slot_free;
    logic                        ram_we;
    logic [dtcd_pkg::PTR_W-1:0]  ram_waddr;
    logic [7:0]                  ram_wdata;
    logic                        ram_re;
    logic [dtcd_pkg::PTR_W-1:0]  ram_raddr;
    logic [7:0]                  ram_rdata;

    dtcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_slot_free (slot_free),
        .i_cmdq_full (cmdq_full),
        .o_cmdq      (cmdq_in),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata)
    );

    dtcd_ram #(
        .WIDTH (8),
        .DEPTH (dtcd_pkg::BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dtcd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmdq  (cmdq_in),
        .o_full  (cmdq_full),
        .o_cmdq  (cmdq_out),
        .i_pop   (cmdq_pop)
    );

    dtcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmdq       (cmdq_out),
        .o_pop        (cmdq_pop),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_slot_free  (slot_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

[rtl/dtcd_checker.sv]
// Port-level checker for the command deframer, bound to the top level.
`include "dual_terminator_command_deframer_macros.svh"

module dtcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_last
);

    // An offered frame byte is withdrawn only by a completed transaction.
    `DTCD_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid)

    `DTCD_ASSERT(a_out_stable, o_valid && i_stall |=> $stable(o_frame_byte) && $stable(o_frame_last))

    // Reset leaves nothing to deliver and the ring ready for input.
    `DTCD_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !o_valid)

    `DTCD_ASSERT_RST(a_rst_ready, !i_rst_n |=> !o_stall)

endmodule

bind dual_terminator_command_deframer dtcd_checker u_checker (.*);

[verif/deframer_check_pkg.sv]
// Frame predictor and result scoreboard for the command deframer testbench.
package deframer_check_pkg;

    import dtcd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    class frame_scoreboard;
        logic        seen_cr;
        logic [1:0]  ff_count;
        int          held_count;
        logic [7:0]  held_bytes [BUFFER_DEPTH];
        frame_beat_t expected_beats [$];
        int          mismatches;

        function new();
            seen_cr    = 1'b0;
            ff_count   = 2'd0;
            held_count = 0;
            mismatches = 0;
        endfunction

        // Moves the held bytes of a finished frame into the expected beats.
        function void release_frame();
            frame_beat_t beat;
            for (int k = 0; k < held_count; k++) begin
                beat.data = held_bytes[k];
                beat.last = (k == held_count - 1);
                expected_beats.push_back(beat);
            end
            held_count = 0;
        endfunction

        // Notes one byte taken by the block and predicts what it causes.
        function void take_rx_byte(logic [7:0] rx);
            if (rx == CHAR_CR) begin
                seen_cr = 1'b1;
                return;
            end
            seen_cr = 1'b0;
            if (rx == CHAR_LF) begin
                // The 0xFF run is deliberately left alone by a line feed.
                release_frame();
                return;
            end
            if (rx == CHAR_FF) begin
                if (ff_count == 2'd2) begin
                    ff_count = 2'd0;
                    release_frame();
                    return;
                end
                ff_count = ff_count + 2'd1;
            end else begin
                ff_count = 2'd0;
            end
            if (held_count < BUFFER_DEPTH - 1) begin
                held_bytes[held_count] = rx;
                held_count++;
            end
        endfunction

        // Compares one transaction from the output channel with the oldest prediction.
        function void check_frame_byte(logic [7:0] data, logic last);
            frame_beat_t want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame byte %02h last %0b", data, last);
                return;
            end
            want = expected_beats.pop_front();
            if (data !== want.data || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                             want.data, want.last, data, last);
            end
        endfunction
    endclass

endpackage

[verif/tb_dual_terminator_command_deframer.sv]
// Testbench of the dual-terminator command deframer with random idling on both channels.
module tb_dual_terminator_command_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import dtcd_pkg::*;
    import deframer_check_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200_000;

    typedef enum int {END_LF, END_CRLF, END_FF} frame_end_e;

    localparam logic [7:0] DIRECTED [26] = '{
        8'h00, CHAR_FF, CHAR_LF,
        CHAR_FF, CHAR_FF,
        CHAR_LF,
        CHAR_CR, CHAR_LF,
        8'h41, CHAR_CR, CHAR_LF,
        8'h7F, 8'h80, CHAR_CR, 8'h55, CHAR_LF,
        CHAR_FF, CHAR_CR, CHAR_FF, CHAR_LF, CHAR_FF,
        8'hFE, 8'h01, CHAR_FF, CHAR_FF, CHAR_FF
    };

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_frame_byte;
    logic       o_frame_last;

    frame_scoreboard sb = new();

    int   cycle_count   = 0;
    int   items_sent    = 0;
    logic sender_burst  = 1'b0;
    logic hold_off_req  = 1'b0;

    dual_terminator_command_deframer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one byte, after a drawn gap outside sender bursts, and holds it until the block takes it.
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        sb.take_rx_byte(rx);
        if (rx != CHAR_CR)
            items_sent++;
    endtask

    // Sends random frame content, kept clear of CR and LF, then a terminator.
    task automatic send_frame(input int len, input frame_end_e ending);
        logic [7:0] rx;
        for (int k = 0; k < len; k++) begin
            rx = 8'($urandom_range(0, 255));
            if (rx == CHAR_CR || rx == CHAR_LF)
                rx = rx ^ 8'h40;
            if ($urandom_range(0, 9) == 0)
                rx = CHAR_FF;
            send_byte(rx);
        end
        case (ending)
            END_LF: send_byte(CHAR_LF);
            END_CRLF: begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default: repeat (3) send_byte(CHAR_FF);
        endcase
    endtask

    task automatic wait_for_drain();
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // Output side: random stalls, burst stretches, and one long hold-off on request.
    initial begin
        int unsigned hold;
        logic        recv_burst;
        recv_burst = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0)
                recv_burst = !recv_burst;
            hold = recv_burst ? 0 : $urandom_range(0, 7);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            sb.check_frame_byte(o_frame_byte, o_frame_last);
        end
    end

    initial begin
        int len;
        int pick;
        logic first_frame;
        logic [7:0] rx;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k])
            send_byte(DIRECTED[k]);
        i_valid <= 1'b0;
        wait_for_drain();

        // The long receiver hold-off lands on the first random frame, which overflows.
        hold_off_req = 1'b1;
        sender_burst = 1'b1;
        first_frame  = 1'b1;
        items_sent   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!first_frame && $urandom_range(0, 4) == 0)
                sender_burst = !sender_burst;
            pick = $urandom_range(0, 99);
            if (first_frame || pick < 85) begin
                pick = $urandom_range(0, 99);
                if (first_frame)
                    len = 70;
                else if (pick < 70)
                    len = $urandom_range(0, 12);
                else if (pick < 93)
                    len = $urandom_range(13, 62);
                else
                    len = $urandom_range(63, 75);
                send_frame(len, frame_end_e'($urandom_range(0, 2)));
                first_frame = 1'b0;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: rx = CHAR_CR;
                        1: rx = CHAR_LF;
                        2: rx = CHAR_FF;
                        default: rx = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(rx);
                end
            end
        end
        // Close any open frame so that everything held comes out.
        send_byte(CHAR_LF);
        i_valid <= 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (sb.expected_beats.size() != 0)
                $display("%0d frame bytes never arrived", sb.expected_beats.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[dual_terminator_command_deframer.f]
+incdir+rtl
rtl/dtcd_pkg.sv
rtl/dtcd_ram.sv
rtl/dtcd_front.sv
rtl/dtcd_cmdq.sv
rtl/dtcd_back.sv
rtl/dual_terminator_command_deframer.sv
rtl/dtcd_checker.sv
verif/deframer_check_pkg.sv
verif/tb_dual_terminator_command_deframer.sv
